// ===== src/tspd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the three-step phase demodulator.
// No dependencies; every other file under src refers to this package by scoped names.
package tspd_pkg;

  localparam int CORDIC_STEPS = 30;
  // lane depth: sums, T/X/D, products, init, then one CORDIC step per stage
  localparam int LANE_LAT     = CORDIC_STEPS + 4;
  localparam int ANGLE_W      = 36;   // Q30 radians, covers 3*pi
  localparam int LIM_W        = 23;   // 81 * 255 * 255
  localparam int THR_W        = 8;
  localparam int AMP_W        = 12;
  localparam int NEAR_PH_W    = 16;
  localparam int FAR_PH_W     = 18;

  localparam logic [THR_W-1:0]     THR_RESET    = 8'd10;
  localparam logic [AMP_W-1:0]     AMP_MAX      = 12'd4095;
  localparam logic [NEAR_PH_W-1:0] NEAR_INVALID = 16'h8000;
  localparam logic [FAR_PH_W-1:0]  FAR_INVALID  = 18'h38000;

  localparam logic signed [ANGLE_W-1:0] PI_Q30    = 36'sd3373259426;
  localparam logic signed [32:0]        SQRT3_Q30 = 33'sd1859775393;

  // atan(2^-i) in Q30, rounded
  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
    32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
    32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
    32'd262144,    32'd131072,    32'd65536,     32'd32768,
    32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,
    32'd64,        32'd32,        32'd16,        32'd8,
    32'd4,         32'd2
  };

endpackage

// ===== src/tspd_lane.sv =====
`timescale 1ns / 1ps
// One board position: grey sums, bias, Q = X^2 + 3D^2, pipelined isqrt
// for amplitude and a pipelined CORDIC for the phase. Uses tspd_pkg.
module tspd_lane #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic clk,
  input  logic en,
  input  logic [23:0] shot0,
  input  logic [23:0] shot1,
  input  logic [23:0] shot2,
  output logic [2*(CHANNEL_BITS+2)+2:0] q,
  output logic [tspd_pkg::AMP_W-1:0] amplitude,
  output logic [tspd_pkg::AMP_W-1:0] bias,
  output logic signed [tspd_pkg::ANGLE_W-1:0] angle
);
  localparam int CB   = CHANNEL_BITS;
  localparam int EW   = 3 * CB;
  localparam int SW   = CB + 2;
  localparam int TW   = SW + 2;
  localparam int XW   = SW + 2;
  localparam int DW   = SW + 1;
  localparam int QW   = 2 * SW + 3;
  localparam int SQW  = (QW + 11) / 2;
  localparam int RAD  = 2 * SQW;
  localparam int REMW = SQW + 3;
  localparam int CW   = SW + 35;
  localparam int AW   = tspd_pkg::ANGLE_W;
  localparam int NS   = tspd_pkg::CORDIC_STEPS;
  localparam int YMW  = DW + 33;
  // bias = floor((32T + 9) / 18) by reciprocal multiply
  localparam int BNW  = TW + 5;
  localparam int BK   = BNW + 5;
  localparam int BMW  = BK - 3;
  localparam logic [BMW-1:0] BM = BMW'(((64'd1 << BK) + 64'd17) / 64'd18);
  // amplitude = floor((r + 9) / 18)
  localparam int ANW  = SQW + 1;
  localparam int AK   = ANW + 5;
  localparam int AMW  = AK - 3;
  localparam logic [AMW-1:0] AM = AMW'(((64'd1 << AK) + 64'd17) / 64'd18);
  localparam int AMP_DLY = NS - 1 - SQW;

  logic [EW-1:0] e0, e1, e2;
  assign e0 = EW'(shot0);
  assign e1 = EW'(shot1);
  assign e2 = EW'(shot2);

  // stage 1: channel sums
  logic [SW-1:0] s0_r, s1_r, s2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= SW'(e0[CB-1:0]) + SW'(e0[2*CB-1:CB]) + SW'(e0[3*CB-1:2*CB]);
      s1_r <= SW'(e1[CB-1:0]) + SW'(e1[2*CB-1:CB]) + SW'(e1[3*CB-1:2*CB]);
      s2_r <= SW'(e2[CB-1:0]) + SW'(e2[2*CB-1:CB]) + SW'(e2[3*CB-1:2*CB]);
    end
  end

  // stage 2: T, X, D
  logic [TW-1:0]        t_r;
  logic signed [XW-1:0] x_r;
  logic signed [DW-1:0] d_r;
  logic signed [XW-1:0] x_nxt;
  logic signed [DW-1:0] d_nxt;
  logic                 z_r;
  assign x_nxt = $signed({1'b0, s0_r, 1'b0}) - $signed({2'b00, s1_r})
               - $signed({2'b00, s2_r});
  assign d_nxt = $signed({1'b0, s2_r}) - $signed({1'b0, s1_r});
  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= TW'(s0_r) + TW'(s1_r) + TW'(s2_r);
      x_r <= x_nxt;
      d_r <= d_nxt;
      z_r <= (x_nxt == '0) && (d_nxt == '0);
    end
  end

  // stage 3: products
  logic signed [2*XW-1:0]  xx_r;
  logic signed [2*DW-1:0]  dd_r;
  logic signed [YMW-1:0]   ym_r;
  logic [BNW+BMW-1:0]      bp_r;
  logic signed [XW-1:0]    x3_r;
  logic                    z3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= x_r * x_r;
      dd_r <= d_r * d_r;
      ym_r <= YMW'(d_r) * YMW'(tspd_pkg::SQRT3_Q30);
      bp_r <= (BNW+BMW)'({t_r, 5'b00000} + BNW'(9)) * (BNW+BMW)'(BM);
      x3_r <= x_r;
      z3_r <= z_r;
    end
  end

  // stage 4: Q, bias, CORDIC start vector
  logic [QW-1:0] xq, dq, q_nxt;
  logic [BNW+BMW-BK-1:0] bq;
  logic [tspd_pkg::AMP_W-1:0] b4_r;
  logic [QW-1:0] q4_r;
  logic signed [CW-1:0] xi, yi;
  assign xq    = QW'($unsigned(xx_r));
  assign dq    = QW'($unsigned(dd_r));
  assign q_nxt = xq + (dq << 1) + dq;
  assign bq    = bp_r[BNW+BMW-1:BK];
  assign xi    = CW'(x3_r) <<< 30;
  assign yi    = CW'(ym_r);

  logic signed [CW-1:0] cx [NS+1];
  logic signed [CW-1:0] cy [NS+1];
  logic signed [AW-1:0] ca [NS+1];
  logic                 cz [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      q4_r <= q_nxt;
      b4_r <= (bq > (BNW+BMW-BK)'(tspd_pkg::AMP_MAX)) ? tspd_pkg::AMP_MAX
                                                      : tspd_pkg::AMP_W'(bq);
      cz[0] <= z3_r;
      if (xi < 0) begin
        // left half plane: turn by pi first
        cx[0] <= -xi;
        cy[0] <= -yi;
        ca[0] <= (yi >= 0) ? tspd_pkg::PI_Q30 : -tspd_pkg::PI_Q30;
      end else begin
        cx[0] <= xi;
        cy[0] <= yi;
        ca[0] <= '0;
      end
    end
  end

  // CORDIC vectoring, one step per stage
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CW-1:0] xs, ys;
    logic signed [AW-1:0] at;
    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    assign at = AW'(tspd_pkg::ATAN_Q30[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        cz[i+1] <= cz[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          ca[i+1] <= ca[i] + at;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          ca[i+1] <= ca[i] - at;
        end
      end
    end
  end

  assign angle = cz[NS] ? '0 : ca[NS];

  // digit-by-digit square root of 1024*Q, one root bit per stage
  logic [RAD-1:0]  rad  [SQW+1];
  logic [REMW-1:0] rem  [SQW+1];
  logic [SQW-1:0]  root [SQW+1];
  assign rad[0]  = RAD'({q4_r, 10'b0000000000});
  assign rem[0]  = '0;
  assign root[0] = '0;

  for (genvar j = 0; j < SQW; j++) begin : g_sqrt
    logic [REMW-1:0] rt, trial;
    assign rt    = {rem[j][REMW-3:0], rad[j][RAD-1:RAD-2]};
    assign trial = REMW'({root[j], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        rad[j+1] <= rad[j] << 2;
        if (rt >= trial) begin
          rem[j+1]  <= rt - trial;
          root[j+1] <= {root[j][SQW-2:0], 1'b1};
        end else begin
          rem[j+1]  <= rt;
          root[j+1] <= {root[j][SQW-2:0], 1'b0};
        end
      end
    end
  end

  logic [ANW+AMW-1:0] ap;
  logic [ANW+AMW-AK-1:0] aq;
  logic [tspd_pkg::AMP_W-1:0] amp_dl [AMP_DLY+1];
  assign ap = (ANW+AMW)'(ANW'(root[SQW]) + ANW'(9)) * (ANW+AMW)'(AM);
  assign aq = ap[ANW+AMW-1:AK];
  always_ff @(posedge clk) begin
    if (en) begin
      amp_dl[0] <= (aq > (ANW+AMW-AK)'(tspd_pkg::AMP_MAX)) ? tspd_pkg::AMP_MAX
                                                           : tspd_pkg::AMP_W'(aq);
      for (int k = 0; k < AMP_DLY; k++) amp_dl[k+1] <= amp_dl[k];
    end
  end
  assign amplitude = amp_dl[AMP_DLY];

  // align Q and bias with the CORDIC output
  logic [QW-1:0]              q_dl [NS];
  logic [tspd_pkg::AMP_W-1:0] b_dl [NS];
  always_ff @(posedge clk) begin
    if (en) begin
      q_dl[0] <= q4_r;
      b_dl[0] <= b4_r;
      for (int k = 0; k < NS - 1; k++) begin
        q_dl[k+1] <= q_dl[k];
        b_dl[k+1] <= b_dl[k];
      end
    end
  end
  assign q    = q_dl[NS-1];
  assign bias = b_dl[NS-1];

endmodule

// ===== src/tspd_merge.sv =====
`timescale 1ns / 1ps
// Combines the two lanes: threshold test, phase unwrap and rounding to the
// output scale, into the output register. Uses tspd_pkg.
module tspd_merge #(
  parameter int QW              = 23,
  parameter int PHASE_FRAC_BITS = 13
) (
  input  logic clk,
  input  logic en,
  input  logic [tspd_pkg::LIM_W-1:0] lim,
  input  logic [QW-1:0] n_q,
  input  logic [QW-1:0] f_q,
  input  logic signed [tspd_pkg::ANGLE_W-1:0] n_ang,
  input  logic signed [tspd_pkg::ANGLE_W-1:0] f_ang,
  input  logic [tspd_pkg::AMP_W-1:0] n_amp,
  input  logic [tspd_pkg::AMP_W-1:0] f_amp,
  input  logic [tspd_pkg::AMP_W-1:0] n_bias,
  input  logic [tspd_pkg::AMP_W-1:0] f_bias,
  output logic [tspd_pkg::NEAR_PH_W-1:0] near_phase,
  output logic [tspd_pkg::FAR_PH_W-1:0] far_phase,
  output logic [tspd_pkg::AMP_W-1:0] near_amplitude,
  output logic [tspd_pkg::AMP_W-1:0] far_amplitude,
  output logic [tspd_pkg::AMP_W-1:0] near_bias,
  output logic [tspd_pkg::AMP_W-1:0] far_bias,
  output logic pixel_valid
);
  localparam int AW = tspd_pkg::ANGLE_W;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (29 - PHASE_FRAC_BITS);

  logic [QW-1:0] lim_q;
  logic ok;
  logic signed [AW-1:0] fa, nr, fr;
  assign lim_q = QW'(lim);
  assign ok    = !((n_q < lim_q) || (f_q < lim_q));
  assign fa    = (n_ang > f_ang) ? f_ang + (tspd_pkg::PI_Q30 <<< 1) : f_ang;
  assign nr    = (n_ang + HALF) >>> (30 - PHASE_FRAC_BITS);
  assign fr    = (fa + HALF) >>> (30 - PHASE_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      near_phase     <= ok ? nr[tspd_pkg::NEAR_PH_W-1:0] : tspd_pkg::NEAR_INVALID;
      far_phase      <= ok ? fr[tspd_pkg::FAR_PH_W-1:0] : tspd_pkg::FAR_INVALID;
      near_amplitude <= n_amp;
      far_amplitude  <= f_amp;
      near_bias      <= n_bias;
      far_bias       <= f_bias;
      pixel_valid    <= ok;
    end
  end

endmodule

// ===== src/three_step_phase_demodulator.sv =====
`timescale 1ns / 1ps
// Three-step phase demodulator: takes one pixel word per clock unless stalled
// and returns one result word per pixel, registered through channel sums, T/X/D,
// products, vector setup, 30 CORDIC stages and one merge stage. Near and far
// positions run in two identical lanes; the square root runs beside the CORDIC.
// A stall on valid output freezes the whole pipeline, so in_stall follows it.
// The threshold is applied in the merge stage and reaches it through thr_r and
// lim_r after a write, so write it only while no pixel is in flight.
// Depends on tspd_pkg, tspd_lane and tspd_merge.
module three_step_phase_demodulator #(
  parameter int PHASE_FRAC_BITS = 13,
  parameter int CHANNEL_BITS    = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [23:0] in_near_shot0,
  input  logic [23:0] in_near_shot1,
  input  logic [23:0] in_near_shot2,
  input  logic [23:0] in_far_shot0,
  input  logic [23:0] in_far_shot1,
  input  logic [23:0] in_far_shot2,
  output logic out_valid,
  input  logic out_stall,
  output logic [15:0] out_near_phase,
  output logic [17:0] out_far_phase,
  output logic [11:0] out_near_amplitude,
  output logic [11:0] out_far_amplitude,
  output logic [11:0] out_near_bias,
  output logic [11:0] out_far_bias,
  output logic out_pixel_valid,
  input  logic cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  localparam int QW  = 2 * (CHANNEL_BITS + 2) + 3;
  localparam int LAT = tspd_pkg::LANE_LAT + 1;
  localparam int AW  = tspd_pkg::ANGLE_W;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [tspd_pkg::THR_W-1:0] thr_r;
  logic [tspd_pkg::LIM_W-1:0] lim_r;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= tspd_pkg::THR_RESET;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_wr_en) thr_r <= cfg_wr_data;
    end
  end

  // 81 * t * t, compared against Q exactly
  always_ff @(posedge clk) begin
    lim_r <= tspd_pkg::LIM_W'(thr_r) * tspd_pkg::LIM_W'(thr_r) * tspd_pkg::LIM_W'(81);
  end

  logic [QW-1:0] n_q, f_q;
  logic [tspd_pkg::AMP_W-1:0] n_amp, f_amp, n_bias, f_bias;
  logic signed [AW-1:0] n_ang, f_ang;

  tspd_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_near (
    .clk(clk), .en(en),
    .shot0(in_near_shot0), .shot1(in_near_shot1), .shot2(in_near_shot2),
    .q(n_q), .amplitude(n_amp), .bias(n_bias), .angle(n_ang)
  );

  tspd_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_far (
    .clk(clk), .en(en),
    .shot0(in_far_shot0), .shot1(in_far_shot1), .shot2(in_far_shot2),
    .q(f_q), .amplitude(f_amp), .bias(f_bias), .angle(f_ang)
  );

  tspd_merge #(.QW(QW), .PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_merge (
    .clk(clk), .en(en), .lim(lim_r),
    .n_q(n_q), .f_q(f_q), .n_ang(n_ang), .f_ang(f_ang),
    .n_amp(n_amp), .f_amp(f_amp), .n_bias(n_bias), .f_bias(f_bias),
    .near_phase(out_near_phase), .far_phase(out_far_phase),
    .near_amplitude(out_near_amplitude), .far_amplitude(out_far_amplitude),
    .near_bias(out_near_bias), .far_bias(out_far_bias),
    .pixel_valid(out_pixel_valid)
  );

endmodule

// ===== src/tspd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for three_step_phase_demodulator, bound to the top.
// Uses tspd_pkg for the invalid phase codes.
module tspd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [15:0] out_near_phase,
  input logic [17:0] out_far_phase,
  input logic out_pixel_valid
);
  // held word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_near_phase)
      && $stable(out_far_phase) && $stable(out_pixel_valid))
    else $error("stalled output word changed");

  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |->
      out_near_phase == tspd_pkg::NEAR_INVALID && out_far_phase == tspd_pkg::FAR_INVALID)
    else $error("invalid pixel without invalid phase codes");

  // unwrapped far phase never below near phase
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_valid |->
      $signed(out_far_phase) >= $signed({{2{out_near_phase[15]}}, out_near_phase}))
    else $error("far phase below near phase");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind three_step_phase_demodulator tspd_checker u_tspd_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_near_phase(out_near_phase),
  .out_far_phase(out_far_phase), .out_pixel_valid(out_pixel_valid)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for three_step_phase_demodulator: random and corner-case pixel
// words, predicted results, random input gaps and output stalls. Needs only the RTL.
module tb_top;

  typedef logic [5:0][23:0] pixel_t;  // near0..2 in [0..2], far0..2 in [3..5]

  typedef struct packed {
    logic [15:0] near_phase;
    logic [17:0] far_phase;
    logic [11:0] near_amp;
    logic [11:0] far_amp;
    logic [11:0] near_bias;
    logic [11:0] far_bias;
    logic        pix_ok;
  } demod_res_t;

  class demod_scoreboard;
    demod_res_t expected_q[$];
    longint     atan_q30[30];
    longint     pi_q30;
    longint     sqrt3_q30;
    int         thr;
    int         errors;
    int         checked;
    int         valid_seen;

    function new();
      for (int i = 0; i < 30; i++) atan_q30[i] = longint'($atan(2.0 ** (-i)) * 2.0 ** 30);
      pi_q30    = longint'($acos(-1.0) * 2.0 ** 30);
      sqrt3_q30 = isqrt(64'd3 << 60);
      thr       = 10;
    endfunction

    function longint isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint vector_angle(longint xc, longint d);
      longint x, y, acc, xs, ys;
      if (xc == 0 && d == 0) return 0;
      x = xc * (64'sd1 <<< 30);
      y = d * sqrt3_q30;
      acc = 0;
      if (x < 0) begin
        acc = (y >= 0) ? pi_q30 : -pi_q30;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; acc += atan_q30[i];
        end else begin
          x -= ys; y += xs; acc -= atan_q30[i];
        end
      end
      return acc;
    endfunction

    function longint chan_sum(logic [23:0] w);
      return longint'(w[7:0]) + longint'(w[15:8]) + longint'(w[23:16]);
    endfunction

    // one board position: energy Q, amplitude, bias and Q30 angle
    function void position(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                           output longint q, output longint amp,
                           output longint bias, output longint ang);
      longint s0, s1, s2, xc, d;
      s0 = chan_sum(a); s1 = chan_sum(b); s2 = chan_sum(c);
      xc = 2 * s0 - s1 - s2;
      d  = s2 - s1;
      q  = xc * xc + 3 * d * d;
      bias = (32 * (s0 + s1 + s2) + 9) / 18;
      amp  = (isqrt(1024 * q) + 9) / 18;
      if (bias > 4095) bias = 4095;
      if (amp > 4095) amp = 4095;
      ang = vector_angle(xc, d);
    endfunction

    function void note_pixel(pixel_t p);
      longint nq, na, nb, nang, fq, fa, fb, fang, lim, np, fp;
      demod_res_t r;
      position(p[0], p[1], p[2], nq, na, nb, nang);
      position(p[3], p[4], p[5], fq, fa, fb, fang);
      lim = 81 * thr * thr;
      r.pix_ok = !(nq < lim || fq < lim);
      if (r.pix_ok) begin
        if (nang > fang) fang += 2 * pi_q30;
        np = (nang + (64'sd1 <<< 16)) >>> 17;
        fp = (fang + (64'sd1 <<< 16)) >>> 17;
      end else begin
        np = -32768;
        fp = -32768;
      end
      r.near_phase = np[15:0];
      r.far_phase  = fp[17:0];
      r.near_amp   = na[11:0];
      r.far_amp    = fa[11:0];
      r.near_bias  = nb[11:0];
      r.far_bias   = fb[11:0];
      expected_q = {expected_q, r};
    endfunction

    function void check_result(demod_res_t a);
      demod_res_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (a.pix_ok) valid_seen++;
      if (a.near_phase !== e.near_phase) begin
        $error("near_phase exp %0d got %0d", $signed(e.near_phase), $signed(a.near_phase));
        errors++;
      end
      if (a.far_phase !== e.far_phase) begin
        $error("far_phase exp %0d got %0d", $signed(e.far_phase), $signed(a.far_phase));
        errors++;
      end
      if (a.near_amp !== e.near_amp) begin
        $error("near_amplitude exp %0d got %0d", e.near_amp, a.near_amp);
        errors++;
      end
      if (a.far_amp !== e.far_amp) begin
        $error("far_amplitude exp %0d got %0d", e.far_amp, a.far_amp);
        errors++;
      end
      if (a.near_bias !== e.near_bias) begin
        $error("near_bias exp %0d got %0d", e.near_bias, a.near_bias);
        errors++;
      end
      if (a.far_bias !== e.far_bias) begin
        $error("far_bias exp %0d got %0d", e.far_bias, a.far_bias);
        errors++;
      end
      if (a.pix_ok !== e.pix_ok) begin
        $error("pixel_valid exp %0d got %0d", e.pix_ok, a.pix_ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  pixel_t      pix = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_near_phase;
  logic [17:0] out_far_phase;
  logic [11:0] out_near_amplitude, out_far_amplitude, out_near_bias, out_far_bias;
  logic        out_pixel_valid;
  logic        cfg_wr_en = 0;
  logic [7:0]  cfg_wr_data = '0;

  demod_scoreboard sb = new();
  int stall_pct = 0;
  int cycles = 0;
  int words_sent = 0;

  always #1 clk = ~clk;

  three_step_phase_demodulator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_near_shot0(pix[0]), .in_near_shot1(pix[1]), .in_near_shot2(pix[2]),
    .in_far_shot0(pix[3]), .in_far_shot1(pix[4]), .in_far_shot2(pix[5]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_near_phase(out_near_phase), .out_far_phase(out_far_phase),
    .out_near_amplitude(out_near_amplitude), .out_far_amplitude(out_far_amplitude),
    .out_near_bias(out_near_bias), .out_far_bias(out_far_bias),
    .out_pixel_valid(out_pixel_valid),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // receiver: check accepted words, then pick next stall
  always @(posedge clk) begin
    cycles++;
    if (cycles > 300000) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_near_phase, out_far_phase, out_near_amplitude,
                       out_far_amplitude, out_near_bias, out_far_bias, out_pixel_valid});
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_pixel(pixel_t p);
    in_valid <= 1;
    pix      <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(p);
    words_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 0;
    pix      <= pixel_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_threshold(logic [7:0] v);
    cfg_wr_en   <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 0;
    sb.thr = v;
    @(posedge clk);
  endtask

  function automatic logic [23:0] grey_word(int g);
    return {g[7:0], g[7:0], g[7:0]};
  endfunction

  // mostly fringe-like pixels; some low-contrast ones near the threshold
  function automatic pixel_t random_pixel();
    pixel_t p;
    int kind, base, spread;
    kind = $urandom_range(3);
    for (int k = 0; k < 6; k++) begin
      if (kind == 0) begin
        p[k] = 24'($urandom);
      end else begin
        base   = (k % 3 == 0) ? $urandom_range(255) : base;
        spread = (kind == 1) ? 40 : 255;
        for (int c = 0; c < 3; c++)
          p[k][c*8 +: 8] = 8'($urandom_range(spread) * (kind == 1 ? 1 : 1) + base);
      end
    end
    return p;
  endfunction

  task automatic random_burst(int n);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (left > 0) begin
          send_pixel(random_pixel());
          left--;
        end
      end
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [7:0] thr_list[6] = '{8'd0, 8'd255, 8'd1, 8'd40, 8'd10, 8'd0};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // corners at the reset threshold: flat, extremes, zero sine with negative cosine
    send_pixel('0);
    send_pixel({6{24'hFFFFFF}});
    send_pixel({grey_word(255), grey_word(255), 24'h0, grey_word(255), grey_word(255), 24'h0});
    send_pixel({24'h0, 24'h0, grey_word(255), 24'h0, 24'h0, grey_word(255)});
    send_pixel({24'h0, grey_word(255), 24'h0, grey_word(255), 24'h0, 24'h0});
    send_pixel({grey_word(255), 24'h0, 24'h0, 24'h0, 24'h0, grey_word(255)});
    send_pixel({24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h0000FF, 24'h00FF00, 24'hFF0000});
    send_pixel({grey_word(30), grey_word(60), grey_word(90),
                grey_word(90), grey_word(60), grey_word(30)});
    send_pixel({grey_word(100), grey_word(100), grey_word(130),
                grey_word(100), grey_word(100), grey_word(130)});
    send_pixel({grey_word(7), grey_word(0), grey_word(0), grey_word(7), grey_word(0), grey_word(0)});
    drain();

    foreach (thr_list[i]) begin
      write_threshold(thr_list[i]);
      stall_pct = (i % 3 == 0) ? 0 : $urandom_range(10, 60);
      send_pixel({24'h0, 24'h0, grey_word(255), grey_word(255), 24'h0, 24'h0});
      send_pixel({grey_word(0), grey_word(0), grey_word(0),
                  grey_word(255), grey_word(255), grey_word(255)});
      random_burst(60);
      if (i == 2) drain();  // hold off until the pipe is empty, then resume
      random_burst(10);
      drain();
    end

    $display("Sent %0d pixel words over %0d thresholds, %0d checked, %0d valid.",
             words_sent, 7, sb.checked, sb.valid_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== three_step_phase_demodulator.f =====
src/tspd_pkg.sv
src/tspd_lane.sv
src/tspd_merge.sv
src/three_step_phase_demodulator.sv
src/tspd_checker.sv
test/tb_top.sv
